// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the clock source monitor checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSM_ASSERT_IMP(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("csm assertion failed");

// next-cycle implication
`define CSM_ASSERT_NXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("csm assertion failed");

`endif

// ----- hw/rtl/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg
// Types, constants and helpers shared by the clock source monitor.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int NUM_SOURCES = 3;
   localparam int TIME_W      = 64;
   localparam int TICK_W      = 44;
   localparam int RATING_W    = 10;
   localparam int SRC_W       = 2;
   localparam int KIND_W      = 2;
   localparam int STRIKE_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int SCALE_EXT   = 7;
   localparam int SCALED_W    = TIME_W + SCALE_EXT;

   // source indexes
   localparam logic [SRC_W-1:0] SRC_CYCLE = 2'd0;
   localparam logic [SRC_W-1:0] SRC_EVENT = 2'd1;
   localparam logic [SRC_W-1:0] SRC_TICK  = 2'd2;
   localparam logic [SRC_W-1:0] SRC_NONE  = 2'd3;

   // word kinds
   localparam logic [KIND_W-1:0] KIND_SELECT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WATCHDOG = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RATING_CYCLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATING_EVENT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATING_TICK  = 2'd2;

   localparam logic [RATING_W-1:0] RATING_CYCLE_RST = 10'd200;
   localparam logic [RATING_W-1:0] RATING_EVENT_RST = 10'd250;
   localparam logic [RATING_W-1:0] RATING_TICK_RST  = 10'd100;
   localparam logic [RATING_W-1:0] RATING_FLOOR     = 10'd100;

   localparam logic [TIME_W-1:0]   JUMP_LIMIT   = 64'd3600000000000;
   localparam logic [TIME_W-1:0]   MIN_MARGIN   = 64'd10000000;
   localparam logic [STRIKE_W-1:0] STRIKE_LIMIT = 2'd2;

   typedef logic [RATING_W-1:0] rating_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] cycle_counter_ns;
      logic [TIME_W-1:0] event_timer_ns;
      logic              event_timer_present;
      logic [TICK_W-1:0] tick_count;
   } req_word_type;

   typedef struct packed {
      logic [TIME_W-1:0]      time_ns;
      logic [SRC_W-1:0]       current_source;
      logic [SRC_W-1:0]       watchdog_source;
      logic [STRIKE_W-1:0]    strike_count;
      logic [NUM_SOURCES-1:0] unstable_mask;
      logic                   jump_rejected;
      logic                   source_switched;
   } rsp_word_type;

   typedef struct packed {
      logic             found;
      logic [SRC_W-1:0] best;
      logic [SRC_W-1:0] second;
   } sel_result_type;

   // tick_count * 1000000, wraps at 64 bits
   function automatic logic [TIME_W-1:0] tick_to_ns(input logic [TICK_W-1:0] ticks);
      logic [TIME_W-1:0] x;
      x = {{(TIME_W-TICK_W){1'b0}}, ticks};
      return (x << 19) + (x << 18) + (x << 17) + (x << 16)
           + (x << 14) + (x << 9) + (x << 6);
   endfunction

endpackage

// ----- hw/rtl/csm_csr.sv -----
// ----------------------------------------------------------------------------
// csm_csr
// Source rating registers, write only.
// ----------------------------------------------------------------------------
module csm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [csm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csm_pkg::RATING_W-1:0]       csr_wdata,
   output csm_pkg::rating_type                rating [csm_pkg::NUM_SOURCES]
);
   import csm_pkg::*;

   rating_type rating_ff [NUM_SOURCES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rating_ff[0] <= RATING_CYCLE_RST;
         rating_ff[1] <= RATING_EVENT_RST;
         rating_ff[2] <= RATING_TICK_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RATING_CYCLE: rating_ff[0] <= csr_wdata;
            CSR_RATING_EVENT: rating_ff[1] <= csr_wdata;
            CSR_RATING_TICK:  rating_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rating = rating_ff;

endmodule

// ----- hw/rtl/csm_select.sv -----
// ----------------------------------------------------------------------------
// csm_select
// Picks best and second-best usable source by rating; ties keep the lower index.
// ----------------------------------------------------------------------------
module csm_select (
   input  logic [csm_pkg::NUM_SOURCES-1:0] usable,
   input  csm_pkg::rating_type             rating [csm_pkg::NUM_SOURCES],
   output csm_pkg::sel_result_type         sel
);
   import csm_pkg::*;

   always_comb begin
      logic             best_ok, sec_ok;
      logic [SRC_W-1:0] best_idx, sec_idx;
      rating_type       best_rt, sec_rt;
      best_ok  = 1'b0;
      sec_ok   = 1'b0;
      best_idx = SRC_NONE;
      sec_idx  = SRC_NONE;
      best_rt  = '0;
      sec_rt   = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         if (usable[i]) begin
            if (!best_ok || rating[i] > best_rt) begin
               if (best_ok && best_rt >= RATING_FLOOR) begin
                  sec_ok  = 1'b1;
                  sec_idx = best_idx;
                  sec_rt  = best_rt;
               end
               best_ok  = 1'b1;
               best_idx = SRC_W'(i);
               best_rt  = rating[i];
            end else if ((!sec_ok || rating[i] > sec_rt) && rating[i] >= RATING_FLOOR) begin
               sec_ok  = 1'b1;
               sec_idx = SRC_W'(i);
               sec_rt  = rating[i];
            end
         end
      end
      sel.found  = best_ok;
      sel.best   = best_idx;
      sel.second = sec_idx;
   end

endmodule

// ----- hw/rtl/csm_core.sv -----
// ----------------------------------------------------------------------------
// csm_core
// Monitor state and the single-pass update for one word: selection, rebase,
// monotonic read with jump rejection, and the watchdog drift check.
// ----------------------------------------------------------------------------
module csm_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  csm_pkg::req_word_type         item,
   input  logic [csm_pkg::TIME_W-1:0]    tick_ns,
   input  csm_pkg::rating_type           rating [csm_pkg::NUM_SOURCES],
   output csm_pkg::rsp_word_type         rsp_next
);
   import csm_pkg::*;

   logic [TIME_W-1:0]      mono_ff, mono_in;
   logic [SRC_W-1:0]       cur_ff, cur_in;
   logic [SRC_W-1:0]       wdg_ff, wdg_in;
   logic [TIME_W-1:0]      offset_ff [NUM_SOURCES];
   logic [TIME_W-1:0]      offset_in [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] unstable_ff, unstable_in;
   logic                   armed_ff, armed_in;
   logic [TIME_W-1:0]      last_cur_ff, last_cur_in;
   logic [TIME_W-1:0]      last_ref_ff, last_ref_in;
   logic [STRIKE_W-1:0]    strikes_ff, strikes_in;

   logic [NUM_SOURCES-1:0] present;
   logic                   cur_valid, wdg_valid;
   logic [TIME_W-1:0]      cur_read, cur_off, cur_now, wdg_read, sel_read, base;
   logic [TIME_W-1:0]      now_rd, rd_delta;
   logic                   rd_gt, jump;
   logic [TIME_W-1:0]      cur_delta, ref_delta, diff;
   logic [SCALED_W-1:0]    diff_x, diff_scaled;
   logic                   ticks, cd_gt, suspect;
   logic [STRIKE_W-1:0]    strikes_inc;
   logic                   rejected, mark, run_sel, armed_a, switched;
   logic [STRIKE_W-1:0]    strikes_a;
   sel_result_type         sel;

   assign present[0] = (item.cycle_counter_ns != '0);
   assign present[1] = item.event_timer_present;
   assign present[2] = 1'b1;

   assign cur_valid = (cur_ff != SRC_NONE);
   assign wdg_valid = (wdg_ff != SRC_NONE);

   always_comb begin
      case (cur_ff)
         SRC_CYCLE: begin cur_read = item.cycle_counter_ns; cur_off = offset_ff[0]; end
         SRC_EVENT: begin cur_read = item.event_timer_ns;   cur_off = offset_ff[1]; end
         SRC_TICK:  begin cur_read = tick_ns;               cur_off = offset_ff[2]; end
         default:   begin cur_read = '0;                    cur_off = '0;           end
      endcase
      case (wdg_ff)
         SRC_CYCLE: wdg_read = item.cycle_counter_ns;
         SRC_EVENT: wdg_read = item.event_timer_ns;
         SRC_TICK:  wdg_read = tick_ns;
         default:   wdg_read = '0;
      endcase
      case (sel.best)
         SRC_CYCLE: sel_read = item.cycle_counter_ns;
         SRC_EVENT: sel_read = item.event_timer_ns;
         SRC_TICK:  sel_read = tick_ns;
         default:   sel_read = '0;
      endcase
   end

   assign cur_now = cur_read + cur_off;

   // read path
   assign now_rd   = cur_valid ? cur_now :
                     (present[0] ? item.cycle_counter_ns : tick_ns);
   assign rd_gt    = (now_rd > mono_ff);
   assign rd_delta = now_rd - mono_ff;
   assign jump     = rd_gt && (mono_ff != '0) && (rd_delta > JUMP_LIMIT);

   // watchdog: diff > dw/k  <=>  dw < diff*k
   assign cur_delta = cur_now - last_cur_ff;
   assign ref_delta = wdg_read - last_ref_ff;
   assign ticks     = (wdg_ff == SRC_TICK);
   assign cd_gt     = (cur_delta > ref_delta);
   assign diff      = cd_gt ? (cur_delta - ref_delta) : (ref_delta - cur_delta);
   assign diff_x    = {{SCALE_EXT{1'b0}}, diff};
   assign diff_scaled = ticks ? ((diff_x << 4) + (diff_x << 2))
                              : ((diff_x << 6) + (diff_x << 5) + (diff_x << 2));
   assign suspect   = (diff > MIN_MARGIN)
                    && ({{SCALE_EXT{1'b0}}, ref_delta} < diff_scaled)
                    && !(ticks && cd_gt);
   assign strikes_inc = (strikes_ff >= STRIKE_LIMIT) ? STRIKE_LIMIT
                                                     : strikes_ff + STRIKE_W'(1);

   always_comb begin
      mono_in     = mono_ff;
      last_cur_in = last_cur_ff;
      last_ref_in = last_ref_ff;
      armed_a     = armed_ff;
      strikes_a   = strikes_ff;
      rejected    = 1'b0;
      mark        = 1'b0;
      run_sel     = 1'b0;
      case (item.kind)
         KIND_SELECT: run_sel = 1'b1;
         KIND_READ: begin
            if (jump) begin
               rejected = 1'b1;
               if (cur_valid) begin
                  mark    = 1'b1;
                  run_sel = 1'b1;
               end
            end else if (rd_gt) begin
               mono_in = now_rd;
            end
         end
         KIND_WATCHDOG: begin
            if (cur_valid && wdg_valid) begin
               last_cur_in = cur_now;
               last_ref_in = wdg_read;
               armed_a     = 1'b1;
               if (armed_ff) begin
                  if (suspect) begin
                     strikes_a = strikes_inc;
                     if (strikes_inc >= STRIKE_LIMIT) begin
                        mark    = 1'b1;
                        run_sel = 1'b1;
                     end
                  end else begin
                     strikes_a = '0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign unstable_in = unstable_ff
                      | (mark ? (NUM_SOURCES'(1) << cur_ff) : '0);

   csm_select u_select (
      .usable (present & ~unstable_in),
      .rating (rating),
      .sel    (sel)
   );

   assign base = (mono_ff != '0) ? mono_ff : (cur_valid ? cur_now : '0);

   always_comb begin
      cur_in     = cur_ff;
      wdg_in     = wdg_ff;
      offset_in  = offset_ff;
      armed_in   = armed_a;
      strikes_in = strikes_a;
      switched   = 1'b0;
      if (run_sel && sel.found) begin
         if (sel.best != cur_ff) begin
            switched = 1'b1;
            cur_in   = sel.best;
            if (base != '0) begin
               offset_in[sel.best] = base - sel_read;
            end
         end
         wdg_in     = sel.second;
         armed_in   = 1'b0;
         strikes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff     <= '0;
         cur_ff      <= SRC_NONE;
         wdg_ff      <= SRC_NONE;
         offset_ff   <= '{default: '0};
         unstable_ff <= '0;
         armed_ff    <= 1'b0;
         last_cur_ff <= '0;
         last_ref_ff <= '0;
         strikes_ff  <= '0;
      end else if (step_en) begin
         mono_ff     <= mono_in;
         cur_ff      <= cur_in;
         wdg_ff      <= wdg_in;
         offset_ff   <= offset_in;
         unstable_ff <= unstable_in;
         armed_ff    <= armed_in;
         last_cur_ff <= last_cur_in;
         last_ref_ff <= last_ref_in;
         strikes_ff  <= strikes_in;
      end
   end

   assign rsp_next.time_ns         = mono_in;
   assign rsp_next.current_source  = cur_in;
   assign rsp_next.watchdog_source = wdg_in;
   assign rsp_next.strike_count    = strikes_in;
   assign rsp_next.unstable_mask   = unstable_in;
   assign rsp_next.jump_rejected   = rejected;
   assign rsp_next.source_switched = switched;

endmodule

// ----- hw/rtl/clock_source_monitor_top.sv -----
// ----------------------------------------------------------------------------
// clock_source_monitor_top
// Selects among three time sources and serves clamped monotonic time.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle unless the result side stalls, and
// each gives exactly one result word. The rate is set by the monitor state
// update, which completes in the single pass between the input register and
// the result register. Users must write ratings through the csr_ port only
// while no word is in flight; the block itself does not enforce this.
module clock_source_monitor_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  csm_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output csm_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_write_en,
   input  logic [csm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [csm_pkg::RATING_W-1:0]     csr_wdata
);
   import csm_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_word_type      in_word_ff;
   logic [TIME_W-1:0] in_tick_ns_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_word_type      out_word_ff;
   rsp_word_type      rsp_next;
   logic              advance, accept;
   rating_type        rating [NUM_SOURCES];

   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff    <= req_word;
         in_tick_ns_ff <= tick_to_ns(req_word.tick_count);
      end
      if (advance) begin
         out_word_ff <= rsp_next;
      end
   end

   csm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rating       (rating)
   );

   csm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (in_word_ff),
      .tick_ns  (in_tick_ns_ff),
      .rating   (rating),
      .rsp_next (rsp_next)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ----- hw/rtl/csm_checker.sv -----
// ----------------------------------------------------------------------------
// csm_checker
// Port-level checks for the clock source monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input csm_pkg::req_word_type   req_word,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input csm_pkg::rsp_word_type   rsp_word
);
   import csm_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && !req_stall && (req_word.kind == KIND_READ || !req_stall);

   `CSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `CSM_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `CSM_ASSERT_IMP(a_distinct_src, clock, reset, rsp_valid && rsp_word.watchdog_source != SRC_NONE, rsp_word.current_source != SRC_NONE && rsp_word.current_source != rsp_word.watchdog_source)
   `CSM_ASSERT_IMP(a_switch_src, clock, reset, rsp_valid && rsp_word.source_switched, rsp_word.current_source != SRC_NONE)
   `CSM_ASSERT_IMP(a_strike_sat, clock, reset, rsp_valid || req_seen, !rsp_valid || rsp_word.strike_count <= STRIKE_LIMIT)

endmodule

bind clock_source_monitor_top csm_checker u_csm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ----- bench/csm_status_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csm_status_check
// Watches both channels of the clock source monitor, predicts each result
// word from the accepted request words and the rating writes, and compares
// every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module csm_status_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  csm_pkg::req_word_type            req_word,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  csm_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_write_en,
   input  logic [csm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [csm_pkg::RATING_W-1:0]     csr_wdata,
   output int                               mismatches,
   output int                               status_due_count,
   output int                               words_checked,
   output int                               switch_count,
   output int                               reject_count,
   output int                               strike_words
);
   import csm_pkg::*;

   localparam logic [TIME_W-1:0] NS_PER_TICK = 64'd1000000;

   rating_type             rating [NUM_SOURCES];
   logic [TIME_W-1:0]      mono_last;
   logic [SRC_W-1:0]       cur_src;
   logic [SRC_W-1:0]       guard_src;
   logic [TIME_W-1:0]      src_ofs [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] unstable_q;
   logic                   armed;
   logic [TIME_W-1:0]      last_cur;
   logic [TIME_W-1:0]      last_ref;
   logic [STRIKE_W-1:0]    strikes;
   rsp_word_type           status_due [$];

   function automatic logic [TIME_W-1:0] raw_time(logic [SRC_W-1:0] s, req_word_type w);
      case (s)
         SRC_CYCLE: return w.cycle_counter_ns;
         SRC_EVENT: return w.event_timer_ns;
         default:   return {{(TIME_W-TICK_W){1'b0}}, w.tick_count} * NS_PER_TICK;
      endcase
   endfunction

   function automatic logic usable(logic [SRC_W-1:0] s, req_word_type w);
      if (unstable_q[s]) return 1'b0;
      case (s)
         SRC_CYCLE: return w.cycle_counter_ns != '0;
         SRC_EVENT: return w.event_timer_present;
         default:   return 1'b1;
      endcase
   endfunction

   // best and runner-up by rating, ties to the lower index; returns switch flag
   function automatic logic pick_sources(req_word_type w);
      logic [SRC_W-1:0]  best;
      logic [SRC_W-1:0]  runner_up;
      logic [SRC_W-1:0]  s;
      logic [TIME_W-1:0] base;
      logic              switched;
      best = SRC_NONE;
      runner_up = SRC_NONE;
      switched = 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         s = SRC_W'(i);
         if (usable(s, w)) begin
            if (best == SRC_NONE || rating[s] > rating[best]) begin
               if (best != SRC_NONE && rating[best] >= RATING_FLOOR) runner_up = best;
               best = s;
            end else if ((runner_up == SRC_NONE || rating[s] > rating[runner_up]) &&
                         rating[s] >= RATING_FLOOR) begin
               runner_up = s;
            end
         end
      end
      if (best == SRC_NONE) return 1'b0;
      if (best != cur_src) begin
         base = mono_last;
         if (base == '0 && cur_src != SRC_NONE) base = raw_time(cur_src, w) + src_ofs[cur_src];
         if (base != '0) src_ofs[best] = base - raw_time(best, w);
         cur_src = best;
         switched = 1'b1;
      end
      guard_src = runner_up;
      armed = 1'b0;
      strikes = '0;
      return switched;
   endfunction

   function automatic rsp_word_type next_status(req_word_type w);
      rsp_word_type      st;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] cur_now;
      logic [TIME_W-1:0] ref_now;
      logic [TIME_W-1:0] cur_delta;
      logic [TIME_W-1:0] ref_delta;
      logic [TIME_W-1:0] drift;
      logic [TIME_W-1:0] margin;
      logic              on_ticks;
      logic              suspect;
      logic              rejected;
      logic              switched;
      rejected = 1'b0;
      switched = 1'b0;
      case (w.kind)
         KIND_SELECT: switched = pick_sources(w);
         KIND_READ: begin
            if (cur_src != SRC_NONE) now = raw_time(cur_src, w) + src_ofs[cur_src];
            else if (w.cycle_counter_ns != '0) now = w.cycle_counter_ns;
            else now = raw_time(SRC_TICK, w);
            if (now > mono_last && mono_last != '0 && now - mono_last > JUMP_LIMIT) begin
               rejected = 1'b1;
               if (cur_src != SRC_NONE) begin
                  unstable_q[cur_src] = 1'b1;
                  switched = pick_sources(w);
               end
            end else if (now > mono_last) begin
               mono_last = now;
            end
         end
         KIND_WATCHDOG: begin
            if (cur_src != SRC_NONE && guard_src != SRC_NONE) begin
               cur_now = raw_time(cur_src, w) + src_ofs[cur_src];
               ref_now = raw_time(guard_src, w);
               if (!armed) begin
                  last_cur = cur_now;
                  last_ref = ref_now;
                  armed = 1'b1;
               end else begin
                  cur_delta = cur_now - last_cur;
                  ref_delta = ref_now - last_ref;
                  on_ticks = guard_src == SRC_TICK;
                  drift = cur_delta > ref_delta ? cur_delta - ref_delta : ref_delta - cur_delta;
                  margin = on_ticks ? ref_delta / 64'd20 : ref_delta / 64'd100;
                  if (margin < MIN_MARGIN) margin = MIN_MARGIN;
                  last_cur = cur_now;
                  last_ref = ref_now;
                  // with the tick counter as reference, running fast is tolerated
                  suspect = drift > margin && !(on_ticks && cur_delta > ref_delta);
                  if (suspect) begin
                     if (strikes < STRIKE_LIMIT) strikes++;
                     if (strikes >= STRIKE_LIMIT) begin
                        unstable_q[cur_src] = 1'b1;
                        switched = pick_sources(w);
                     end
                  end else begin
                     strikes = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      st.time_ns = mono_last;
      st.current_source = cur_src;
      st.watchdog_source = guard_src;
      st.strike_count = strikes;
      st.unstable_mask = unstable_q;
      st.jump_rejected = rejected;
      st.source_switched = switched;
      return st;
   endfunction

   task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_status(rsp_word_type want, rsp_word_type got);
      check_field("time_ns", want.time_ns, got.time_ns);
      check_field("current_source", TIME_W'(want.current_source),
                  TIME_W'(got.current_source));
      check_field("watchdog_source", TIME_W'(want.watchdog_source),
                  TIME_W'(got.watchdog_source));
      check_field("strike_count", TIME_W'(want.strike_count), TIME_W'(got.strike_count));
      check_field("unstable_mask", TIME_W'(want.unstable_mask), TIME_W'(got.unstable_mask));
      check_field("jump_rejected", TIME_W'(want.jump_rejected), TIME_W'(got.jump_rejected));
      check_field("source_switched", TIME_W'(want.source_switched),
                  TIME_W'(got.source_switched));
      words_checked++;
      switch_count += int'(want.source_switched);
      reject_count += int'(want.jump_rejected);
      if (want.strike_count != '0) strike_words++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rating[SRC_CYCLE] = RATING_CYCLE_RST;
         rating[SRC_EVENT] = RATING_EVENT_RST;
         rating[SRC_TICK] = RATING_TICK_RST;
         mono_last = '0;
         cur_src = SRC_NONE;
         guard_src = SRC_NONE;
         for (int i = 0; i < NUM_SOURCES; i++) src_ofs[i] = '0;
         unstable_q = '0;
         armed = 1'b0;
         last_cur = '0;
         last_ref = '0;
         strikes = '0;
         status_due.delete();
         mismatches = 0;
         words_checked = 0;
         switch_count = 0;
         reject_count = 0;
         strike_words = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               $error("result word with no prediction waiting");
               mismatches++;
            end else begin
               compare_status(status_due.pop_front(), rsp_word);
            end
         end
         if (req_valid && !req_stall) status_due.push_back(next_status(req_word));
         if (csr_write_en && csr_index < NUM_SOURCES) rating[csr_index] = csr_wdata;
      end
      status_due_count = status_due.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the clock source monitor. A directed sequence walks
// selection, rebasing, clamping, watchdog strikes and the no-usable-source
// case, then phases of modeled source readings with rare jumps, skews and
// dropouts run under several rating settings, and a last phase of raw noise.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import csm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] HOUR_PLUS   = 64'd7200000000000;
   localparam logic [TIME_W-1:0] STEP_BACK   = 64'd600000000;
   localparam logic [TIME_W-1:0] SKEW_STEP   = 64'd80000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [RATING_W-1:0]    csr_wdata = '0;

   int mismatches;
   int status_due_count;
   int words_checked;
   int switch_count;
   int reject_count;
   int strike_words;

   req_word_type      stim_q [$];
   logic [TIME_W-1:0] wall_ns = 64'd60000000000;
   logic [TIME_W-1:0] cycle_skew = 64'd3000000000;
   logic [TIME_W-1:0] event_skew = 64'd25000000000;
   logic [TIME_W-1:0] fault_step = '0;
   int                fault_left = 0;
   logic              fault_on_cycle = 1'b0;
   int                hold_requests = 0;
   int                holds_served = 0;
   int                hold_left = 0;
   int                stall_mode = 0;
   int                mode_left = 0;

   always #6 clock = ~clock;

   clock_source_monitor_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   csm_status_check status_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .status_due_count (status_due_count),
      .words_checked    (words_checked),
      .switch_count     (switch_count),
      .reject_count     (reject_count),
      .strike_words     (strike_words)
   );

   // result side: stall pattern changes each time mode_left runs out, plus long holds
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = 300;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            2:       rsp_stall <= $urandom_range(0, 3) != 0;
            default: rsp_stall <= (mode_left % 5) < 2;
         endcase
      end
   end

   initial begin
      #5000000;
      $display("[clock_source_monitor_top] ERROR");
      $finish;
   end

   function automatic req_word_type make_req(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] cyc,
                                             logic [TIME_W-1:0] evt, logic present,
                                             logic [TICK_W-1:0] ticks);
      req_word_type w;
      w.kind = kind;
      w.cycle_counter_ns = cyc;
      w.event_timer_ns = evt;
      w.event_timer_present = present;
      w.tick_count = ticks;
      return w;
   endfunction

   task automatic write_ratings(rating_type rc, rating_type re, rating_type rt);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_RATING_CYCLE;
      csr_wdata <= rc;
      @(negedge clock);
      csr_index <= CSR_RATING_EVENT;
      csr_wdata <= re;
      @(negedge clock);
      csr_index <= CSR_RATING_TICK;
      csr_wdata <= rt;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock); while (status_due_count != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_all();
      int burst_left;
      int gap;
      burst_left = 0;
      while (stim_q.size() != 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_word <= stim_q.pop_front();
         do @(posedge clock); while (req_stall);
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // readings follow one wall clock; rare jumps, step-backs and drift stretches
   task automatic queue_traffic(int count);
      int                pick;
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] cyc;
      for (int n = 0; n < count; n++) begin
         wall_ns += TIME_W'($urandom_range(0, 250000000));
         if ($urandom_range(0, 399) == 0) begin
            if ($urandom_range(0, 1)) cycle_skew += HOUR_PLUS;
            else event_skew += HOUR_PLUS;
         end
         if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 1)) cycle_skew -= STEP_BACK;
            else event_skew -= STEP_BACK;
         end
         if (fault_left == 0 && $urandom_range(0, 199) == 0) begin
            fault_left = $urandom_range(2, 5);
            fault_on_cycle = 1'($urandom_range(0, 1));
            fault_step = $urandom_range(0, 1) ? SKEW_STEP : -SKEW_STEP;
         end
         if (fault_left > 0) begin
            fault_left--;
            if (fault_on_cycle) cycle_skew += fault_step;
            else event_skew += fault_step;
         end
         pick = $urandom_range(0, 31);
         if (pick < 4) kind = KIND_SELECT;
         else if (pick < 17) kind = KIND_READ;
         else if (pick < 31) kind = KIND_WATCHDOG;
         else kind = KIND_UNUSED;
         cyc = ($urandom_range(0, 19) == 0) ? '0 : wall_ns + cycle_skew;
         stim_q.push_back(make_req(kind, cyc, wall_ns + event_skew,
                                   $urandom_range(0, 14) != 0,
                                   TICK_W'(wall_ns / 64'd1000000)));
      end
   endtask

   task automatic queue_noise(int count);
      for (int n = 0; n < count; n++) begin
         stim_q.push_back(make_req(KIND_W'($urandom_range(0, 3)), {$urandom(), $urandom()},
                                   {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
                                   TICK_W'({$urandom(), $urandom()})));
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      write_ratings(RATING_CYCLE_RST, RATING_EVENT_RST, RATING_TICK_RST);

      // no source yet, then tick only, then rebase onto the event timer
      stim_q.push_back(make_req(KIND_WATCHDOG, 64'd5000000000, 64'd7000000000, 1'b1, 44'd5));
      stim_q.push_back(make_req(KIND_READ, '0, 64'd9000000000, 1'b1, '0));
      stim_q.push_back(make_req(KIND_UNUSED, '1, '1, 1'b1, '1));
      stim_q.push_back(make_req(KIND_SELECT, '0, '1, 1'b0, '1));
      stim_q.push_back(make_req(KIND_WATCHDOG, '0, '0, 1'b0, 44'd1));
      stim_q.push_back(make_req(KIND_SELECT, '0, 64'd30000000000, 1'b1, 44'd1000));
      stim_q.push_back(make_req(KIND_READ, '0, 64'd30002000000, 1'b1, 44'd1002));
      // tick counter as reference: fast tolerated, slow strikes, good clears
      stim_q.push_back(make_req(KIND_WATCHDOG, '0, 64'd31000000000, 1'b1, 44'd2000));
      stim_q.push_back(make_req(KIND_WATCHDOG, '0, 64'd32300000000, 1'b1, 44'd3000));
      stim_q.push_back(make_req(KIND_WATCHDOG, '0, 64'd33000000000, 1'b1, 44'd4000));
      stim_q.push_back(make_req(KIND_WATCHDOG, '0, 64'd34000000000, 1'b1, 44'd5000));
      stim_q.push_back(make_req(KIND_READ, '0, 64'd34005000000, 1'b1, 44'd5005));
      stim_q.push_back(make_req(KIND_READ, '0, 64'd31000000000, 1'b1, 44'd5006));
      stim_q.push_back(make_req(KIND_SELECT, 64'd40000000000, 64'd35000000000, 1'b1, 44'd6000));
      send_all();
      drain();

      // tick counter preferred, then two strikes drop it
      write_ratings(RATING_CYCLE_RST, RATING_EVENT_RST, 10'd1023);
      stim_q.push_back(make_req(KIND_SELECT, 64'd41000000000, 64'd36000000000, 1'b1, 44'd7000));
      stim_q.push_back(make_req(KIND_WATCHDOG, 64'd42000000000, 64'd37000000000, 1'b1, 44'd8000));
      stim_q.push_back(make_req(KIND_WATCHDOG, 64'd43000000000, 64'd38200000000, 1'b1, 44'd9000));
      stim_q.push_back(make_req(KIND_WATCHDOG, 64'd44000000000, 64'd39400000000, 1'b1,
                                44'd10000));
      stim_q.push_back(make_req(KIND_READ, 64'd44100000000, 64'd39500000000, 1'b1, 44'd10100));
      stim_q.push_back(make_req(KIND_SELECT, '0, 64'd39600000000, 1'b0, 44'd10200));
      send_all();
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1:       write_ratings(10'd1023, 10'd1023, 10'd1023);
            2:       write_ratings(10'd0, 10'd0, 10'd0);
            3:       write_ratings(10'd100, 10'd99, 10'd101);
            default: write_ratings(rating_type'($urandom_range(0, 1023)),
                                   rating_type'($urandom_range(0, 1023)),
                                   rating_type'($urandom_range(0, 1023)));
         endcase
         if (phase == 2) hold_requests++;
         queue_traffic(220);
         send_all();
         drain();
      end

      queue_noise(40);
      send_all();
      drain();
      repeat (10) @(posedge clock);

      $display("checked %0d result words: %0d source switches, %0d rejected jumps,",
               words_checked, switch_count, reject_count);
      $display("%0d words with watchdog strikes pending", strike_words);
      if (mismatches == 0 && status_due_count == 0) begin
         $display("[clock_source_monitor_top] OK");
      end else begin
         $display("[clock_source_monitor_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- clock_source_monitor_top.f -----
+incdir+hw/rtl
hw/rtl/csm_pkg.sv
hw/rtl/csm_csr.sv
hw/rtl/csm_select.sv
hw/rtl/csm_core.sv
hw/rtl/clock_source_monitor_top.sv
hw/rtl/csm_checker.sv
bench/csm_status_check.sv
bench/tb_top.sv
